### src/hsces_pkg.sv
// ----------------------------------------------------------------------------
// hsces_pkg
// shared constants for the hitting set critical edge store
// ----------------------------------------------------------------------------
`default_nettype none

package hsces_pkg;

  localparam int MAX_VERTICES_DEF = 16;
  localparam int MAX_EDGES_DEF    = 64;

  localparam logic [1:0] FN_LOAD    = 2'd0;
  localparam logic [1:0] FN_RESTART = 2'd1;
  localparam logic [1:0] FN_ADD     = 2'd2;
  localparam logic [1:0] FN_POP     = 2'd3;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_REJECTED  = 3'd1;
  localparam logic [2:0] ST_FULL      = 3'd2;
  localparam logic [2:0] ST_POP_EMPTY = 3'd3;
  localparam logic [2:0] ST_BAD_VTX   = 3'd4;

  localparam logic CFG_EDGE_COUNT   = 1'b0;
  localparam logic CFG_VERTEX_COUNT = 1'b1;

endpackage

`default_nettype wire

### src/hitting_set_critical_edge_store_unit.sv
// ----------------------------------------------------------------------------
// hitting_set_critical_edge_store_unit
// state store for a minimal hitting set search: vertex rows, vertex stack,
// per-level critical edge bitmaps, candidate masks and uncovered edges
// ----------------------------------------------------------------------------
// load, restart, bad vertex, full stack and empty pop go from idle to the
// result state, pop via the pop write state, add checks each stack entry
// then writes the new level; one critical bitmap a cycle through the
// critical memory (check and copy share that pass); in_ready only while idle,
// new commands wait until the result is registered, so hold-off stalls input
// reset: stack empty, all edges uncovered, level zero candidates all set
`default_nettype none

module hitting_set_critical_edge_store_unit #(
  parameter int MAX_VERTICES = hsces_pkg::MAX_VERTICES_DEF,
  parameter int MAX_EDGES    = hsces_pkg::MAX_EDGES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic [6:0]  cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_func,
  input  wire logic [3:0]  in_vertex,
  input  wire logic [63:0] in_edge_row,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       out_status,
  output logic [4:0]       out_depth,
  output logic [63:0]      out_uncovered,
  output logic [15:0]      out_candidates
);

  localparam int VW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int DW = $clog2(MAX_VERTICES + 1);
  localparam int CRIT_DEPTH = (MAX_VERTICES + 1) * MAX_VERTICES;
  localparam int AW = $clog2(CRIT_DEPTH);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_ACHK = 5'b00010,
    S_ANEW = 5'b00100,
    S_POPW = 5'b01000,
    S_FIN  = 5'b10000
  } state_t;

  typedef logic [MAX_EDGES-1:0]    edges_t;
  typedef logic [MAX_VERTICES-1:0] verts_t;

  state_t             state_r;
  logic [6:0]         edge_cnt_r;
  logic [4:0]         vtx_cnt_r;
  logic [DW-1:0]      depth_r;
  edges_t             unc_r;
  verts_t             cand_r [MAX_VERTICES+1];
  edges_t             hit_rows_r [MAX_VERTICES];
  logic [VW-1:0]      chosen_r [MAX_VERTICES];
  edges_t             crit_mem [CRIT_DEPTH];
  edges_t             rd_q;
  edges_t             h_r;
  logic [VW-1:0]      v_r;
  logic [VW-1:0]      i_r;
  logic               rej_r;
  logic [2:0]         status_r;
  logic               out_valid_r;
  logic [2:0]         out_status_r;
  logic [4:0]         out_depth_r;
  logic [63:0]        out_unc_r;
  logic [15:0]        out_cand_r;

  logic [7:0]         lim;
  edges_t             edge_fill;
  verts_t             vtx_fill;
  logic [AW-1:0]      rd_addr;
  logic [AW-1:0]      wr_addr;
  edges_t             wr_data;
  logic               wr_en;
  logic [VW-1:0]      in_v;
  logic               chk_last;
  logic [DW-1:0]      d_m1;
  logic               out_load;

  function automatic logic [AW-1:0] crit_addr(input logic [DW-1:0] lvl,
                                              input logic [DW-1:0] idx);
    return AW'(lvl) * AW'(MAX_VERTICES) + AW'(idx);
  endfunction

  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == S_IDLE);
  assign in_v      = VW'(in_vertex);
  assign d_m1      = depth_r - DW'(1);
  assign chk_last  = (DW'(i_r) + DW'(1)) == depth_r;
  assign out_load  = (state_r == S_FIN) && (!out_valid_r || out_ready);

  assign lim = (8'(vtx_cnt_r) > 8'(MAX_VERTICES)) ? 8'(MAX_VERTICES) : 8'(vtx_cnt_r);

  always_comb begin
    for (int b = 0; b < MAX_EDGES; b++) begin
      edge_fill[b] = 8'(b) < 8'(edge_cnt_r);
    end
    for (int b = 0; b < MAX_VERTICES; b++) begin
      vtx_fill[b] = 8'(b) < 8'(vtx_cnt_r);
    end
  end

  // critical memory port control
  always_comb begin
    rd_addr = '0;
    wr_addr = '0;
    wr_data = '0;
    wr_en   = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_func == hsces_pkg::FN_POP) begin
          rd_addr = crit_addr(depth_r, d_m1);
        end else begin
          rd_addr = crit_addr(depth_r, '0);
        end
      end
      S_ACHK: begin
        rd_addr = crit_addr(depth_r, DW'(i_r) + DW'(1));
        wr_addr = crit_addr(depth_r + DW'(1), DW'(i_r));
        wr_data = rd_q & ~h_r;
        wr_en   = 1'b1;
      end
      S_ANEW: begin
        wr_addr = crit_addr(depth_r + DW'(1), depth_r);
        wr_data = h_r & unc_r;
        wr_en   = !rej_r;
      end
      S_POPW, S_FIN: begin
        rd_addr = '0;
      end
      default: begin
        rd_addr = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      crit_mem[wr_addr] <= wr_data;
    end
    rd_q <= crit_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      edge_cnt_r  <= 7'd64;
      vtx_cnt_r   <= 5'd16;
      depth_r     <= '0;
      unc_r       <= '1;
      cand_r[0]   <= (MAX_VERTICES > 16) ? verts_t'(16'hFFFF) : '1;
      out_valid_r <= 1'b0;
      rej_r       <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == hsces_pkg::CFG_EDGE_COUNT) begin
          edge_cnt_r <= cfg_data;
        end else begin
          vtx_cnt_r <= cfg_data[4:0];
        end
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            v_r      <= in_v;
            h_r      <= hit_rows_r[in_v];
            i_r      <= '0;
            rej_r    <= 1'b0;
            unique case (in_func)
              hsces_pkg::FN_LOAD: begin
                state_r <= S_FIN;
                if (8'(in_vertex) >= lim) begin
                  status_r <= hsces_pkg::ST_BAD_VTX;
                end else begin
                  status_r <= hsces_pkg::ST_OK;
                  hit_rows_r[in_v] <= in_edge_row[MAX_EDGES-1:0];
                end
              end
              hsces_pkg::FN_RESTART: begin
                status_r  <= hsces_pkg::ST_OK;
                state_r   <= S_FIN;
                depth_r   <= '0;
                unc_r     <= edge_fill;
                cand_r[0] <= vtx_fill;
              end
              hsces_pkg::FN_ADD: begin
                if (8'(in_vertex) >= lim) begin
                  status_r <= hsces_pkg::ST_BAD_VTX;
                  state_r  <= S_FIN;
                end else if (8'(depth_r) >= lim) begin
                  status_r <= hsces_pkg::ST_FULL;
                  state_r  <= S_FIN;
                end else if (depth_r == '0) begin
                  status_r <= hsces_pkg::ST_OK;
                  state_r  <= S_ANEW;
                end else begin
                  status_r <= hsces_pkg::ST_OK;
                  state_r  <= S_ACHK;
                end
              end
              default: begin
                if (depth_r == '0) begin
                  status_r <= hsces_pkg::ST_POP_EMPTY;
                  state_r  <= S_FIN;
                end else begin
                  status_r <= hsces_pkg::ST_OK;
                  state_r  <= S_POPW;
                end
              end
            endcase
          end
        end
        S_ACHK: begin
          if ((rd_q & ~h_r) == '0) begin
            rej_r <= 1'b1;
          end
          i_r <= i_r + VW'(1);
          if (chk_last) begin
            state_r <= S_ANEW;
          end
        end
        S_ANEW: begin
          if (rej_r) begin
            status_r <= hsces_pkg::ST_REJECTED;
          end else begin
            cand_r[depth_r + DW'(1)] <= cand_r[depth_r] & ~(verts_t'(1) << v_r);
            unc_r                    <= unc_r & ~h_r;
            chosen_r[VW'(depth_r)]   <= v_r;
            depth_r                  <= depth_r + DW'(1);
          end
          state_r <= S_FIN;
        end
        S_POPW: begin
          cand_r[d_m1] <= cand_r[d_m1] | (verts_t'(1) << chosen_r[VW'(d_m1)]);
          unc_r        <= unc_r | rd_q;
          depth_r      <= d_m1;
          state_r      <= S_FIN;
        end
        S_FIN: begin
          if (out_load) begin
            out_status_r <= status_r;
            out_depth_r  <= 5'(depth_r);
            out_unc_r    <= 64'(unc_r);
            out_cand_r   <= 16'(cand_r[depth_r]);
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_depth      = out_depth_r;
  assign out_uncovered  = out_unc_r;
  assign out_candidates = out_cand_r;

endmodule

`default_nettype wire

### dv/tb_hitting_set_critical_edge_store_unit.sv
// ----------------------------------------------------------------------------
// tb_hitting_set_critical_edge_store_unit
// self-checking bench for the hitting set critical edge store: a queue fed
// driver sends load, restart, add and pop commands under random idling, an
// in-bench predictor tracks rows, stack, critical bitmaps, candidates and
// uncovered edges, and a monitor checks every result transfer in order
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_hitting_set_critical_edge_store_unit;

  typedef struct packed {
    logic [1:0]  func;
    logic [3:0]  vertex;
    logic [63:0] row;
  } cmd_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [4:0]  depth;
    logic [63:0] uncovered;
    logic [15:0] candidates;
  } answer_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = hsces_pkg::CFG_EDGE_COUNT;
  logic [6:0]  cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_func = hsces_pkg::FN_LOAD;
  logic [3:0]  in_vertex = '0;
  logic [63:0] in_edge_row = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  out_status;
  logic [4:0]  out_depth;
  logic [63:0] out_uncovered;
  logic [15:0] out_candidates;

  hitting_set_critical_edge_store_unit u_dut (
    .clk, .rst_n, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .in_valid, .in_ready, .in_func, .in_vertex, .in_edge_row,
    .out_valid, .out_ready, .out_status, .out_depth, .out_uncovered,
    .out_candidates
  );

  // predictor state
  logic [63:0] rows_m [16];
  logic [63:0] crit_m [272];
  logic [15:0] cand_m [17];
  logic [3:0]  chosen_m [16];
  logic [63:0] unc_m;
  int          depth_m;
  int          edge_reg;
  int          vtx_reg;

  cmd_t    cmd_queue[$];
  answer_t answer_queue[$];
  cmd_t    cur_cmd;
  int      mismatches = 0;
  int      n_answers = 0;
  int      n_status[8];
  int      in_gap = 0;
  bit      quiet = 1'b0;

  initial forever #5 clk = ~clk;

  initial begin
    #5ms;
    $display("Mismatches found");
    $finish;
  end

  function automatic int vtx_limit();
    return vtx_reg > 16 ? 16 : vtx_reg;
  endfunction

  function automatic logic [63:0] edge_fill(int n);
    if (n >= 64) return '1;
    return (64'd1 << n) - 64'd1;
  endfunction

  function automatic void restart_m();
    depth_m = 0;
    unc_m = edge_fill(edge_reg);
    cand_m[0] = 16'(edge_fill(vtx_limit()));
  endfunction

  function automatic logic [2:0] add_m(int v);
    int d;
    logic [63:0] h;
    d = depth_m;
    if (v >= vtx_limit()) return hsces_pkg::ST_BAD_VTX;
    if (d >= vtx_limit()) return hsces_pkg::ST_FULL;
    h = rows_m[v];
    for (int i = 0; i < d; i++)
      if ((crit_m[d*16+i] & ~h) == 64'd0) return hsces_pkg::ST_REJECTED;
    for (int i = 0; i < d; i++) crit_m[(d+1)*16+i] = crit_m[d*16+i] & ~h;
    crit_m[(d+1)*16+d] = h & unc_m;
    cand_m[d+1] = cand_m[d] & ~(16'd1 << v);
    unc_m = unc_m & ~h;
    chosen_m[d] = 4'(v);
    depth_m = d + 1;
    return hsces_pkg::ST_OK;
  endfunction

  function automatic answer_t predict_answer(cmd_t c);
    answer_t a;
    int d;
    a.status = hsces_pkg::ST_OK;
    case (c.func)
      hsces_pkg::FN_LOAD: begin
        if (c.vertex >= vtx_limit()) a.status = hsces_pkg::ST_BAD_VTX;
        else rows_m[c.vertex] = c.row;
      end
      hsces_pkg::FN_RESTART: restart_m();
      hsces_pkg::FN_ADD: a.status = add_m(int'(c.vertex));
      default: begin
        if (depth_m == 0) a.status = hsces_pkg::ST_POP_EMPTY;
        else begin
          d = depth_m - 1;
          depth_m = d;
          cand_m[d] = cand_m[d] | (16'd1 << chosen_m[d]);
          unc_m = unc_m | crit_m[(d+1)*16+d];
        end
      end
    endcase
    a.depth = 5'(depth_m);
    a.uncovered = unc_m;
    a.candidates = cand_m[depth_m];
    return a;
  endfunction

  task automatic report(string msg);
    $display("MISMATCH at result %0d: %s", n_answers, msg);
    mismatches++;
  endtask

  function automatic void enqueue_cmd(cmd_t c);
    cmd_queue = {cmd_queue, c};
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) answer_queue = {answer_queue, predict_answer(cur_cmd)};
      if (!in_valid || in_ready) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (!quiet && $urandom_range(0, 7) == 0) begin
          in_gap = $urandom_range(1, 12) - 1;
          in_valid <= 1'b0;
        end else if (cmd_queue.size() > 0) begin
          cur_cmd = cmd_queue.pop_front();
          in_valid <= 1'b1;
          in_func <= cur_cmd.func;
          in_vertex <= cur_cmd.vertex;
          in_edge_row <= cur_cmd.row;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver with random stalls and one long hold-off
  int  stall_left = 0;
  int  hold_left = 0;
  int  seen = 0;
  bit  held = 1'b0;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) seen++;
      if (seen == 300 && !held) begin
        held = 1'b1;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 12) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    answer_t want;
    if (rst_n && out_valid && out_ready) begin
      if (answer_queue.size() == 0) begin
        report("result transfer with nothing expected");
      end else begin
        want = answer_queue.pop_front();
        if (out_status !== want.status)
          report($sformatf("status got %h want %h", out_status, want.status));
        if (out_depth !== want.depth)
          report($sformatf("depth got %h want %h", out_depth, want.depth));
        if (out_uncovered !== want.uncovered)
          report($sformatf("uncovered got %h want %h", out_uncovered, want.uncovered));
        if (out_candidates !== want.candidates)
          report($sformatf("candidates got %h want %h", out_candidates, want.candidates));
        n_status[want.status]++;
      end
      n_answers++;
    end
  end

  task automatic write_reg(logic idx, logic [6:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == hsces_pkg::CFG_EDGE_COUNT) edge_reg = int'(val);
    else vtx_reg = int'(val[4:0]);
  endtask

  task automatic drain();
    while (cmd_queue.size() > 0 || in_valid || answer_queue.size() > 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  function automatic cmd_t mk(logic [1:0] f, int v, logic [63:0] r);
    cmd_t c;
    c.func = f;
    c.vertex = 4'(v);
    c.row = r;
    return c;
  endfunction

  function automatic logic [63:0] rand_row();
    logic [63:0] r;
    r = {$urandom, $urandom};
    case ($urandom_range(0, 5))
      0: return r;
      1: return 64'd1 << $urandom_range(0, 63);
      2: return $urandom_range(0, 1) ? '1 : '0;
      3: return r & {$urandom, $urandom};
      default: return r & {$urandom, $urandom} & {$urandom, $urandom};
    endcase
  endfunction

  task automatic random_phase(int n);
    int lim;
    int v;
    int k;
    lim = vtx_limit();
    enqueue_cmd(mk(hsces_pkg::FN_RESTART, 0, '0));
    for (int i = 0; i < n; i++) begin
      if (lim > 0 && $urandom_range(0, 4) != 0) v = $urandom_range(0, lim - 1);
      else v = $urandom_range(0, 15);
      k = $urandom_range(0, 99);
      if (k < 10) enqueue_cmd(mk(hsces_pkg::FN_LOAD, v, rand_row()));
      else if (k < 15) enqueue_cmd(mk(hsces_pkg::FN_RESTART, v, rand_row()));
      else if (k < 70) enqueue_cmd(mk(hsces_pkg::FN_ADD, v, rand_row()));
      else enqueue_cmd(mk(hsces_pkg::FN_POP, v, rand_row()));
    end
  endtask

  int phase_edges [8] = '{64, 8, 1, 127, 0, 20, 64, 0};
  int phase_vtx   [8] = '{16, 4, 1, 127, 0, 16, 3, 0};

  initial begin
    for (int i = 0; i < 272; i++) crit_m[i] = '0;
    for (int i = 0; i < 17; i++) cand_m[i] = '0;
    for (int i = 0; i < 16; i++) begin
      rows_m[i] = '0;
      chosen_m[i] = '0;
    end
    edge_reg = 64;
    vtx_reg = 16;
    restart_m();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed: load every row, then empty pop, rejection and unwind
    for (int v = 0; v < 15; v++) enqueue_cmd(mk(hsces_pkg::FN_LOAD, v, 64'd1 << v));
    enqueue_cmd(mk(hsces_pkg::FN_LOAD, 15, '1));
    enqueue_cmd(mk(hsces_pkg::FN_POP, 0, '0));
    enqueue_cmd(mk(hsces_pkg::FN_ADD, 0, '0));
    enqueue_cmd(mk(hsces_pkg::FN_ADD, 15, '0));
    enqueue_cmd(mk(hsces_pkg::FN_ADD, 0, '0));
    enqueue_cmd(mk(hsces_pkg::FN_ADD, 1, '0));
    enqueue_cmd(mk(hsces_pkg::FN_POP, 0, '0));
    enqueue_cmd(mk(hsces_pkg::FN_POP, 0, '0));
    enqueue_cmd(mk(hsces_pkg::FN_RESTART, 0, '0));
    drain();

    // bad vertex and full stack with a small graph
    write_reg(hsces_pkg::CFG_EDGE_COUNT, 7'd8);
    write_reg(hsces_pkg::CFG_VERTEX_COUNT, 7'd2);
    enqueue_cmd(mk(hsces_pkg::FN_RESTART, 0, '0));
    enqueue_cmd(mk(hsces_pkg::FN_ADD, 0, '0));
    enqueue_cmd(mk(hsces_pkg::FN_ADD, 2, '0));
    enqueue_cmd(mk(hsces_pkg::FN_LOAD, 9, '1));
    enqueue_cmd(mk(hsces_pkg::FN_ADD, 1, '0));
    enqueue_cmd(mk(hsces_pkg::FN_ADD, 0, '0));
    drain();

    for (int p = 0; p < 8; p++) begin
      if (p == 7) begin
        phase_edges[p] = $urandom_range(0, 127);
        phase_vtx[p] = $urandom_range(0, 127);
        quiet = 1'b1;
      end
      write_reg(hsces_pkg::CFG_EDGE_COUNT, 7'(phase_edges[p]));
      write_reg(hsces_pkg::CFG_VERTEX_COUNT, 7'(phase_vtx[p]));
      random_phase(165);
      drain();
    end

    $display("covered %0d results: ok %0d, rejected %0d, full %0d, empty pop %0d,",
             n_answers, n_status[hsces_pkg::ST_OK], n_status[hsces_pkg::ST_REJECTED],
             n_status[hsces_pkg::ST_FULL], n_status[hsces_pkg::ST_POP_EMPTY]);
    $display("bad vertex %0d; register settings swept from zero to saturation, long hold-off",
             n_status[hsces_pkg::ST_BAD_VTX]);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
